/* src/gble_pkg.sv */
package gble_pkg;

  localparam int CAPACITY_DEF = 1024;
  localparam int WINDOW_DEF   = 10;
  localparam int WIN_FIELDS   = 10;

  localparam int OP_W     = 2;
  localparam int CHAR_W   = 8;
  localparam int AMOUNT_W = 11;
  localparam int WLEN_W   = 4;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 96;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_LEFT   = 2'd2,
    OP_RIGHT  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOVE_RD,
    S_MOVE_WR,
    S_WIN_RD,
    S_WIN_CAP,
    S_OUT
  } state_t;

endpackage

/* src/gble_ram.sv */
module gble_ram
  #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
  )
  (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
  );

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* src/gap_buffer_line_editor_core.sv */
// Line-edit buffer held as two stacks in one memory: text left of the cursor grows up
// from address zero, text right of the cursor grows down from the top. Each request
// (insert, delete left, cursor left, cursor right) gives one result with the count of
// characters handled and the last window_length characters left of the cursor. Each
// character moved by a cursor move or read for the window costs one memory read and
// one write or capture through the single read port of the store. No request is taken
// while one is in work; a finished result may wait in the output register while the
// next request is taken.
module gap_buffer_line_editor_core
  import gble_pkg::*;
  #(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int WINDOW   = WINDOW_DEF
  )
  (
    input  logic                  clk,
    input  logic                  rst,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // Fields from bit 0: character (8), amount (11), zero fill (5).
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // Fields from bit 0: operation (2).
    input  logic [OP_W-1:0]       s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // Fields from bit 0: done_count (11), window_length (4), window_char_0 through
    // window_char_9 (8 each), zero fill (1).
    output logic [OUT_DATA_W-1:0] m_axis_tdata
  );

  localparam int AW = $clog2(CAPACITY);
  localparam int LW = $clog2(CAPACITY + 1);
  localparam int CW = (LW > AMOUNT_W) ? LW : AMOUNT_W;

  state_t state;
  state_t state_next;

  op_t                 op_q;
  logic [LW-1:0]       left;
  logic [LW-1:0]       right;
  logic [AMOUNT_W-1:0] done_q;
  logic [AMOUNT_W-1:0] cnt;
  logic [WLEN_W-1:0]   win_idx;
  logic [CHAR_W-1:0]   win_buf [WIN_FIELDS];

  logic                in_accept;
  op_t                 in_op;
  logic [CHAR_W-1:0]   in_char;
  logic [AMOUNT_W-1:0] in_amount;
  logic [LW-1:0]       avail;
  logic [AMOUNT_W-1:0] done_c;
  logic                full;
  logic [WLEN_W-1:0]   wlen;
  logic                out_load;

  logic              ram_wr_en;
  logic [AW-1:0]     ram_wr_addr;
  logic [CHAR_W-1:0] ram_wr_data;
  logic              ram_rd_en;
  logic [AW-1:0]     ram_rd_addr;
  logic [CHAR_W-1:0] ram_rd_data;

  gble_ram #(
    .WIDTH(CHAR_W),
    .DEPTH(CAPACITY)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign s_axis_tready = (state == S_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign in_op         = op_t'(s_axis_tuser);
  assign in_char       = s_axis_tdata[CHAR_W-1:0];
  assign in_amount     = s_axis_tdata[CHAR_W +: AMOUNT_W];

  assign avail  = (in_op == OP_RIGHT) ? right : left;
  assign done_c = (CW'(in_amount) < CW'(avail)) ? in_amount : AMOUNT_W'(avail);
  assign full   = (({1'b0, left} + {1'b0, right}) == (LW + 1)'(CAPACITY));
  assign wlen   = (left < LW'(WINDOW)) ? left[WLEN_W-1:0] : WLEN_W'(WINDOW);

  assign out_load = (state == S_OUT) && (!m_axis_tvalid || m_axis_tready);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_accept) begin
          if (((in_op == OP_LEFT) || (in_op == OP_RIGHT)) && (done_c != '0)) begin
            state_next = S_MOVE_RD;
          end else begin
            state_next = S_WIN_RD;
          end
        end
      end
      S_MOVE_RD: begin
        state_next = S_MOVE_WR;
      end
      S_MOVE_WR: begin
        state_next = (cnt == AMOUNT_W'(1)) ? S_WIN_RD : S_MOVE_RD;
      end
      S_WIN_RD: begin
        state_next = (win_idx == wlen) ? S_OUT : S_WIN_CAP;
      end
      S_WIN_CAP: begin
        state_next = S_WIN_RD;
      end
      S_OUT: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    ram_wr_en   = 1'b0;
    ram_wr_addr = left[AW-1:0];
    ram_wr_data = in_char;
    ram_rd_en   = 1'b0;
    ram_rd_addr = left[AW-1:0];
    unique case (state)
      S_IDLE: begin
        ram_wr_en = in_accept && (in_op == OP_INSERT) && !full;
      end
      S_MOVE_RD: begin
        ram_rd_en = 1'b1;
        if (op_q == OP_LEFT) begin
          ram_rd_addr = AW'(left - LW'(1));
        end else begin
          ram_rd_addr = AW'(LW'(CAPACITY) - right);
        end
      end
      S_MOVE_WR: begin
        ram_wr_en   = 1'b1;
        ram_wr_data = ram_rd_data;
        if (op_q == OP_LEFT) begin
          ram_wr_addr = AW'(LW'(CAPACITY) - right - LW'(1));
        end
      end
      S_WIN_RD: begin
        ram_rd_en   = (win_idx != wlen);
        ram_rd_addr = AW'(left - LW'(wlen) + LW'(win_idx));
      end
      S_WIN_CAP, S_OUT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      left          <= '0;
      right         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (in_accept) begin
        if ((in_op == OP_INSERT) && !full) begin
          left <= left + LW'(1);
        end else if (in_op == OP_DELETE) begin
          left <= left - LW'(done_c);
        end
      end else if (state == S_MOVE_WR) begin
        if (op_q == OP_LEFT) begin
          left  <= left - LW'(1);
          right <= right + LW'(1);
        end else begin
          left  <= left + LW'(1);
          right <= right - LW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_q    <= in_op;
      cnt     <= done_c;
      win_idx <= '0;
      if (in_op == OP_INSERT) begin
        done_q <= full ? '0 : AMOUNT_W'(1);
      end else begin
        done_q <= done_c;
      end
      for (int i = 0; i < WIN_FIELDS; i++) begin
        win_buf[i] <= '0;
      end
    end else if (state == S_MOVE_WR) begin
      cnt <= cnt - AMOUNT_W'(1);
    end else if (state == S_WIN_CAP) begin
      for (int i = 0; i < WIN_FIELDS; i++) begin
        if (win_idx == WLEN_W'(i)) begin
          win_buf[i] <= ram_rd_data;
        end
      end
      win_idx <= win_idx + WLEN_W'(1);
    end
    if (out_load) begin
      m_axis_tdata[AMOUNT_W-1:0]            <= done_q;
      m_axis_tdata[AMOUNT_W +: WLEN_W]      <= wlen;
      for (int i = 0; i < WIN_FIELDS; i++) begin
        m_axis_tdata[AMOUNT_W + WLEN_W + CHAR_W*i +: CHAR_W] <= win_buf[i];
      end
      m_axis_tdata[OUT_DATA_W-1]            <= 1'b0;
    end
  end

endmodule

/* sim/gap_buffer_line_editor_core_test.sv */
module gap_buffer_line_editor_core_test
  import gble_pkg::*;
  ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT   = 20000;
  localparam int DRAIN_CYCLES  = 64;
  localparam int HOLD_AT       = 60;
  localparam int HOLD_CYCLES   = 600;
  localparam int MAX_AMOUNT    = 1024;

  typedef struct packed {
    logic [AMOUNT_W-1:0]               done_count;
    logic [WLEN_W-1:0]                 window_length;
    logic [WIN_FIELDS-1:0][CHAR_W-1:0] window_chars;
  } edit_result_t;

  // Tracks the two stacks of the buffer and the results that each request must give.
  class edit_tracker;
    logic [CHAR_W-1:0] text_mem [CAPACITY_DEF];
    int unsigned left_len;
    int unsigned right_len;
    edit_result_t expected_results[$];
    int errors;

    function new();
      left_len = 0;
      right_len = 0;
      errors = 0;
      foreach (text_mem[k]) text_mem[k] = '0;
    endfunction

    function int unsigned occupancy();
      return left_len + right_len;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void apply_edit(op_t op, logic [CHAR_W-1:0] ch, logic [AMOUNT_W-1:0] amt);
      edit_result_t want;
      int unsigned n;
      int unsigned wlen;
      int unsigned i;
      n = 0;
      case (op)
        OP_INSERT: begin
          if (left_len + right_len < CAPACITY_DEF) begin
            text_mem[left_len] = ch;
            left_len++;
            n = 1;
          end
        end
        OP_DELETE: begin
          n = (amt < left_len) ? amt : left_len;
          left_len -= n;
        end
        OP_LEFT: begin
          n = (amt < left_len) ? amt : left_len;
          for (i = 0; i < n; i++) begin
            left_len--;
            text_mem[CAPACITY_DEF - right_len - 1] = text_mem[left_len];
            right_len++;
          end
        end
        default: begin
          n = (amt < right_len) ? amt : right_len;
          for (i = 0; i < n; i++) begin
            text_mem[left_len] = text_mem[CAPACITY_DEF - right_len];
            left_len++;
            right_len--;
          end
        end
      endcase
      wlen = (left_len < WINDOW_DEF) ? left_len : WINDOW_DEF;
      want.done_count = AMOUNT_W'(n);
      want.window_length = WLEN_W'(wlen);
      want.window_chars = '0;
      for (i = 0; i < wlen; i++) want.window_chars[i] = text_mem[left_len - wlen + i];
      expected_results.push_back(want);
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] data);
      edit_result_t want;
      logic [CHAR_W-1:0] got_char;
      int i;
      if (expected_results.size() == 0) begin
        $error("result %0h arrived with no request outstanding", data);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      if (data[10:0] !== want.done_count) begin
        $error("done_count: expected %0d, actual %0d", want.done_count, data[10:0]);
        errors++;
      end
      if (data[14:11] !== want.window_length) begin
        $error("window_length: expected %0d, actual %0d", want.window_length, data[14:11]);
        errors++;
      end
      for (i = 0; i < WIN_FIELDS; i++) begin
        got_char = data[15 + 8*i +: 8];
        if (got_char !== want.window_chars[i]) begin
          $error("window_char_%0d: expected %0h, actual %0h", i, want.window_chars[i],
                 got_char);
          errors++;
        end
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [OP_W-1:0]       s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  edit_tracker tracker = new();
  int send_calm = 0;
  int recv_calm = 0;
  int results_seen = 0;
  int idle_cycles = 0;

  gap_buffer_line_editor_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Mostly random waits, with an occasional run of back-to-back transfers.
  function automatic int pick_gap(ref int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      calm_left = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 13);
  endfunction

  function automatic logic [AMOUNT_W-1:0] pick_amount();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return AMOUNT_W'($urandom_range(0, 12));
    if (r < 90) return AMOUNT_W'($urandom_range(0, 100));
    if (r < 98) return AMOUNT_W'($urandom_range(0, MAX_AMOUNT));
    return AMOUNT_W'(MAX_AMOUNT);
  endfunction

  task automatic send_request(input op_t op, input logic [CHAR_W-1:0] ch,
                              input logic [AMOUNT_W-1:0] amt);
    int gap;
    gap = pick_gap(send_calm);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, amt, ch};
    s_axis_tuser  <= op;
    do @(posedge clk); while (!s_axis_tready);
    tracker.apply_edit(op, ch, amt);
  endtask

  task automatic random_edits(input int count);
    int k;
    int r;
    op_t op;
    for (k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 45) op = OP_INSERT;
      else if (r < 60) op = OP_DELETE;
      else if (r < 80) op = OP_LEFT;
      else op = OP_RIGHT;
      send_request(op, CHAR_W'($urandom_range(0, 255)), pick_amount());
    end
  endtask

  // Grows the text with mostly inserts, pushing some of it right of the cursor on the way,
  // then sweeps the cursor across the whole text, with inserts and deletes on the way.
  task automatic fill_buffer(input int count);
    int r;
    int k;
    for (k = 0; (k < count) && (tracker.occupancy() < CAPACITY_DEF); k++) begin
      r = $urandom_range(0, 99);
      if (r < 85) send_request(OP_INSERT, CHAR_W'($urandom_range(0, 255)), '0);
      else if (r < 93) send_request(OP_LEFT, '0, AMOUNT_W'($urandom_range(0, 8)));
      else send_request(OP_RIGHT, '0, AMOUNT_W'($urandom_range(0, 8)));
    end
    repeat (3) send_request(OP_INSERT, CHAR_W'($urandom_range(0, 255)), '0);
    send_request(OP_LEFT, '0, AMOUNT_W'(MAX_AMOUNT));
    send_request(OP_INSERT, 8'h3c, '0);
    send_request(OP_RIGHT, '0, AMOUNT_W'(MAX_AMOUNT));
    send_request(OP_LEFT, '0, 11'd500);
    send_request(OP_DELETE, '0, AMOUNT_W'(MAX_AMOUNT));
    send_request(OP_INSERT, 8'hc3, '0);
    send_request(OP_RIGHT, '0, AMOUNT_W'(MAX_AMOUNT));
    send_request(OP_DELETE, '0, 11'd300);
  endtask

  initial begin
    int k;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_request(OP_DELETE, 8'h00, 11'd0);
    send_request(OP_LEFT, 8'hff, 11'd5);
    send_request(OP_RIGHT, 8'h00, AMOUNT_W'(MAX_AMOUNT));
    send_request(OP_INSERT, 8'h00, 11'd0);
    send_request(OP_INSERT, 8'hff, AMOUNT_W'(MAX_AMOUNT));
    for (k = 0; k < 10; k++) send_request(OP_INSERT, CHAR_W'(8'h41 + k), 11'd3);
    send_request(OP_LEFT, 8'h00, 11'd3);
    send_request(OP_RIGHT, 8'h00, 11'd1);
    send_request(OP_RIGHT, 8'h00, AMOUNT_W'(MAX_AMOUNT));
    send_request(OP_LEFT, 8'h00, AMOUNT_W'(MAX_AMOUNT));
    send_request(OP_RIGHT, 8'h00, 11'd7);
    send_request(OP_DELETE, 8'h00, 11'd0);
    send_request(OP_DELETE, 8'h00, 11'd2);
    send_request(OP_DELETE, 8'h00, AMOUNT_W'(MAX_AMOUNT));

    random_edits(250);
    fill_buffer(80);
    random_edits(210);

    s_axis_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Result side; one long hold-off lets the block back up and stall its input.
  initial begin
    int gap;
    do @(posedge clk); while (rst);
    forever begin
      if (results_seen == HOLD_AT) gap = HOLD_CYCLES;
      else gap = pick_gap(recv_calm);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      tracker.check_result(m_axis_tdata);
      results_seen++;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

/* gap_buffer_line_editor_core.f */
src/gble_pkg.sv
src/gble_ram.sv
src/gap_buffer_line_editor_core.sv
sim/gap_buffer_line_editor_core_test.sv
